[rtl/pinhole_point_projection_cull_macros.svh]
// Assertion macros for the pinhole projection RTL.
`ifndef PINHOLE_POINT_PROJECTION_CULL_MACROS_SVH
`define PINHOLE_POINT_PROJECTION_CULL_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define PPC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppc assertion failed");

// Condition must never be true outside reset.
`define PPC_ASSERT_NEVER(label, clk, rst_n, cond) \
  `PPC_ASSERT(label, clk, rst_n, !(cond))

`endif

[rtl/ppc_pkg.sv]
// Package: widths, register indexes and beat types of the projection pipeline.
package ppc_pkg;

  localparam int ID_WIDTH       = 24;
  localparam int COORD_WIDTH    = 32;
  localparam int FRAC_BITS      = 16;
  localparam int DIM_WIDTH      = 13;
  localparam int PIX_WIDTH      = 12;
  localparam int FOCAL_WIDTH    = 32;
  localparam int CENTER_WIDTH   = 29;
  localparam int DEPTH_WIDTH    = 31;
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;

  localparam int Z_WIDTH   = COORD_WIDTH - 1;
  localparam int MAG_WIDTH = COORD_WIDTH;
  localparam int N_WIDTH   = MAG_WIDTH + FOCAL_WIDTH;
  localparam int ZD_WIDTH  = Z_WIDTH + DIM_WIDTH;
  // in-view quotient stays below dim * 2^(FRAC_BITS-1)
  localparam int Q_BITS    = DIM_WIDTH + FRAC_BITS - 1;
  localparam int QM_WIDTH  = Q_BITS + 1;
  localparam int U_WIDTH   = ((CENTER_WIDTH > QM_WIDTH) ? CENTER_WIDTH : QM_WIDTH) + 2;
  localparam int M_WIDTH   = U_WIDTH + 7;
  localparam int R_WIDTH   = U_WIDTH - FRAC_BITS;

  localparam logic [CFG_ADDR_WIDTH-1:0] REG_FOCAL  = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_CCOL   = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_CROW   = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_NEAR   = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_FAR    = 3'd4;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_WIDTH  = 3'd5;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_HEIGHT = 3'd6;

  typedef struct packed {
    logic [ID_WIDTH-1:0]           pt_index;
    logic signed [COORD_WIDTH-1:0] cam_x;
    logic signed [COORD_WIDTH-1:0] cam_y;
    logic signed [COORD_WIDTH-1:0] cam_z;
  } in_item_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]  hit_id;
    logic [PIX_WIDTH-1:0] pixel_col;
    logic [PIX_WIDTH-1:0] pixel_row;
  } out_item_t;

  typedef struct packed {
    logic                vld;
    logic                ok;
    logic                negx;
    logic                negy;
    logic [ID_WIDTH-1:0] id;
  } div_tag_t;

  typedef struct packed {
    logic                 ok;
    logic [PIX_WIDTH-1:0] pix;
  } axis_res_t;

endpackage

[rtl/ppc_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage.
`include "pinhole_point_projection_cull_macros.svh"

module ppc_div
  import ppc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  div_tag_t           in_tag,
  input  logic [Z_WIDTH-1:0] in_z,
  input  logic [N_WIDTH-1:0] in_nx,
  input  logic [N_WIDTH-1:0] in_ny,
  output div_tag_t           out_tag,
  output logic [QM_WIDTH-1:0] out_qx,
  output logic [QM_WIDTH-1:0] out_qy
);

  div_tag_t           tag_r [0:Q_BITS];
  logic [Z_WIDTH-1:0] z_r   [0:Q_BITS];
  logic [Z_WIDTH-1:0] rem_r [0:Q_BITS][0:1];
  logic [Q_BITS-1:0]  nlo_r [0:Q_BITS][0:1];
  logic [Q_BITS-1:0]  quo_r [0:Q_BITS][0:1];

  // stage 0: load the high part of the dividend as the first remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0].vld <= 1'b0;
      tag_r[0].ok  <= 1'b0;
    end else begin
      tag_r[0].vld <= in_tag.vld;
      tag_r[0].ok  <= in_tag.ok;
    end
    tag_r[0].negx <= in_tag.negx;
    tag_r[0].negy <= in_tag.negy;
    tag_r[0].id   <= in_tag.id;
    z_r[0]        <= in_z;
    rem_r[0][0]   <= Z_WIDTH'(in_nx >> Q_BITS);
    rem_r[0][1]   <= Z_WIDTH'(in_ny >> Q_BITS);
    nlo_r[0][0]   <= in_nx[Q_BITS-1:0];
    nlo_r[0][1]   <= in_ny[Q_BITS-1:0];
    quo_r[0][0]   <= '0;
    quo_r[0][1]   <= '0;
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    logic [Z_WIDTH:0] trial_nxt [0:1];
    logic             ge_nxt    [0:1];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial_nxt[l] = {rem_r[k][l], nlo_r[k][l][Q_BITS-1]};
        ge_nxt[l]    = trial_nxt[l] >= {1'b0, z_r[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k+1].vld <= 1'b0;
        tag_r[k+1].ok  <= 1'b0;
      end else begin
        tag_r[k+1].vld <= tag_r[k].vld;
        tag_r[k+1].ok  <= tag_r[k].ok;
      end
      tag_r[k+1].negx <= tag_r[k].negx;
      tag_r[k+1].negy <= tag_r[k].negy;
      tag_r[k+1].id   <= tag_r[k].id;
      z_r[k+1]        <= z_r[k];
      for (int l = 0; l < 2; l++) begin
        rem_r[k+1][l] <= ge_nxt[l] ? Z_WIDTH'(trial_nxt[l] - {1'b0, z_r[k]})
                                   : Z_WIDTH'(trial_nxt[l]);
        nlo_r[k+1][l] <= nlo_r[k][l] << 1;
        quo_r[k+1][l] <= {quo_r[k][l][Q_BITS-2:0], ge_nxt[l]};
      end
    end
  end

  // negative coordinates round toward minus infinity: bump the magnitude
  assign out_tag = tag_r[Q_BITS];
  assign out_qx  = QM_WIDTH'(quo_r[Q_BITS][0]) +
                   QM_WIDTH'(tag_r[Q_BITS].negx && (rem_r[Q_BITS][0] != '0));
  assign out_qy  = QM_WIDTH'(quo_r[Q_BITS][1]) +
                   QM_WIDTH'(tag_r[Q_BITS].negy && (rem_r[Q_BITS][1] != '0));

  `PPC_ASSERT(a_tag_latency, clk, rst_n, out_tag.vld |-> $past(in_tag.vld, Q_BITS + 1))
  `PPC_ASSERT_NEVER(a_ok_without_vld, clk, rst_n, out_tag.ok && !out_tag.vld)
  `PPC_ASSERT(a_rem_below_z, clk, rst_n, out_tag.ok |-> (rem_r[Q_BITS][0] < z_r[Q_BITS]))

endmodule

[rtl/ppc_axis.sv]
// One image axis: add principal point, margin test, then round and clamp.
module ppc_axis
  import ppc_pkg::*;
(
  input  logic                    clk,
  input  logic [QM_WIDTH-1:0]     q_mag,
  input  logic                    neg,
  input  logic [CENTER_WIDTH-1:0] center,
  input  logic [DIM_WIDTH-1:0]    dim,
  output axis_res_t               res
);

  localparam logic [U_WIDTH-1:0] HALF = U_WIDTH'(1) << (FRAC_BITS - 1);
  localparam logic [PIX_WIDTH-1:0] PIX_MAX = '1;

  logic signed [U_WIDTH-1:0] qs;
  logic signed [U_WIDTH-1:0] u;
  logic signed [M_WIDTH-1:0] m;
  logic signed [M_WIDTH-1:0] lo;
  logic signed [M_WIDTH-1:0] hi;
  logic [DIM_WIDTH+6:0]      dim99;
  logic signed [U_WIDTH-1:0] u_r;
  logic                      ok_r;
  logic [U_WIDTH-1:0]        rnd;
  logic [R_WIDTH-1:0]        r;
  logic [DIM_WIDTH-1:0]      dm1;
  logic [PIX_WIDTH-1:0]      lim;

  always_comb begin
    qs    = neg ? -$signed(U_WIDTH'(q_mag)) : $signed(U_WIDTH'(q_mag));
    u     = $signed(U_WIDTH'(center)) + qs;
    m     = M_WIDTH'(u) * $signed(M_WIDTH'(100));
    dim99 = (DIM_WIDTH + 7)'(dim) * 7'd99;
    lo    = $signed(M_WIDTH'({dim, {FRAC_BITS{1'b0}}}));
    hi    = $signed(M_WIDTH'({dim99, {FRAC_BITS{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    u_r  <= u;
    ok_r <= (m >= lo) && (m < hi);
  end

  // round half up, clamp to dim-1 saturated at the pixel range
  always_comb begin
    rnd = $unsigned(u_r) + HALF;
    r   = rnd[U_WIDTH-1:FRAC_BITS];
    dm1 = dim - 1'b1;
    lim = (dim > DIM_WIDTH'(1 << PIX_WIDTH)) ? PIX_MAX : dm1[PIX_WIDTH-1:0];
    res.ok  = ok_r;
    res.pix = (r > R_WIDTH'(lim)) ? lim : r[PIX_WIDTH-1:0];
  end

endmodule

[rtl/pinhole_point_projection_cull.sv]
// A result strobes once its start beat has passed 2 front stages, 29 divider
// stages, 1 margin stage and 1 output register; culled points give no strobe.
// Throughput: one point per cycle; busy stays low, the divider is fully pipelined.
// Reset: synchronous active-low rst_n clears the valid bits and loads the
// register defaults (f=1000, c=960/540, depth 1..400, 1920x1080).
module pinhole_point_projection_cull
  import ppc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  in_item_t                  in_item,
  output logic                      out_strobe,
  output out_item_t                 out_item,
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

  logic [FOCAL_WIDTH-1:0]  focal_r;
  logic [CENTER_WIDTH-1:0] ccol_r;
  logic [CENTER_WIDTH-1:0] crow_r;
  logic [DEPTH_WIDTH-1:0]  near_r;
  logic [DEPTH_WIDTH-1:0]  far_r;
  logic [DIM_WIDTH-1:0]    width_r;
  logic [DIM_WIDTH-1:0]    height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r  <= FOCAL_WIDTH'(65536000);
      ccol_r   <= CENTER_WIDTH'(62914560);
      crow_r   <= CENTER_WIDTH'(35389440);
      near_r   <= DEPTH_WIDTH'(65536);
      far_r    <= DEPTH_WIDTH'(26214400);
      width_r  <= DIM_WIDTH'(1920);
      height_r <= DIM_WIDTH'(1080);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL:  focal_r  <= cfg_wdata[FOCAL_WIDTH-1:0];
        REG_CCOL:   ccol_r   <= cfg_wdata[CENTER_WIDTH-1:0];
        REG_CROW:   crow_r   <= cfg_wdata[CENTER_WIDTH-1:0];
        REG_NEAR:   near_r   <= cfg_wdata[DEPTH_WIDTH-1:0];
        REG_FAR:    far_r    <= cfg_wdata[DEPTH_WIDTH-1:0];
        REG_WIDTH:  width_r  <= cfg_wdata[DIM_WIDTH-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[DIM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: magnitudes and depth window
  logic                   in_acc;
  logic [MAG_WIDTH-1:0]   x_mag;
  logic [MAG_WIDTH-1:0]   y_mag;
  logic [Z_WIDTH-1:0]     z_val;
  logic                   depth_ok;

  assign in_acc   = start && !busy;
  assign x_mag    = in_item.cam_x[COORD_WIDTH-1] ? MAG_WIDTH'(-in_item.cam_x)
                                                 : MAG_WIDTH'(in_item.cam_x);
  assign y_mag    = in_item.cam_y[COORD_WIDTH-1] ? MAG_WIDTH'(-in_item.cam_y)
                                                 : MAG_WIDTH'(in_item.cam_y);
  assign z_val    = in_item.cam_z[Z_WIDTH-1:0];
  assign depth_ok = !in_item.cam_z[COORD_WIDTH-1] && (z_val != '0) &&
                    (z_val >= Z_WIDTH'(near_r)) && (z_val <= Z_WIDTH'(far_r));

  logic                 s1_vld_r;
  logic                 s1_ok_r;
  logic                 s1_negx_r;
  logic                 s1_negy_r;
  logic [ID_WIDTH-1:0]  s1_id_r;
  logic [MAG_WIDTH-1:0] s1_xm_r;
  logic [MAG_WIDTH-1:0] s1_ym_r;
  logic [Z_WIDTH-1:0]   s1_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
    s1_ok_r   <= depth_ok;
    s1_negx_r <= in_item.cam_x[COORD_WIDTH-1];
    s1_negy_r <= in_item.cam_y[COORD_WIDTH-1];
    s1_id_r   <= in_item.pt_index;
    s1_xm_r   <= x_mag;
    s1_ym_r   <= y_mag;
    s1_z_r    <= z_val;
  end

  // stage 2: products for the view test and the dividends
  logic                 s2_vld_r;
  logic                 s2_ok_r;
  logic                 s2_negx_r;
  logic                 s2_negy_r;
  logic [ID_WIDTH-1:0]  s2_id_r;
  logic [N_WIDTH-1:0]   s2_nx_r;
  logic [N_WIDTH-1:0]   s2_ny_r;
  logic [ZD_WIDTH-1:0]  s2_zw_r;
  logic [ZD_WIDTH-1:0]  s2_zh_r;
  logic [Z_WIDTH-1:0]   s2_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_ok_r   <= s1_ok_r;
    s2_negx_r <= s1_negx_r;
    s2_negy_r <= s1_negy_r;
    s2_id_r   <= s1_id_r;
    s2_nx_r   <= s1_xm_r * focal_r;
    s2_ny_r   <= s1_ym_r * focal_r;
    s2_zw_r   <= s1_z_r * width_r;
    s2_zh_r   <= s1_z_r * height_r;
    s2_z_r    <= s1_z_r;
  end

  // view test: 2|c|f < z*dim*2^FRAC_BITS; this also bounds the quotient
  logic     view_x;
  logic     view_y;
  div_tag_t div_in_tag;
  div_tag_t div_out_tag;
  logic [QM_WIDTH-1:0] qx;
  logic [QM_WIDTH-1:0] qy;

  assign view_x = {s2_nx_r, 1'b0} < (N_WIDTH + 1)'({s2_zw_r, {FRAC_BITS{1'b0}}});
  assign view_y = {s2_ny_r, 1'b0} < (N_WIDTH + 1)'({s2_zh_r, {FRAC_BITS{1'b0}}});

  always_comb begin
    div_in_tag.vld  = s2_vld_r;
    div_in_tag.ok   = s2_vld_r && s2_ok_r && view_x && view_y;
    div_in_tag.negx = s2_negx_r;
    div_in_tag.negy = s2_negy_r;
    div_in_tag.id   = s2_id_r;
  end

  ppc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (div_in_tag),
    .in_z    (s2_z_r),
    .in_nx   (s2_nx_r),
    .in_ny   (s2_ny_r),
    .out_tag (div_out_tag),
    .out_qx  (qx),
    .out_qy  (qy)
  );

  // margin stage lives in the axis units; carry the tag alongside
  div_tag_t  ax_tag_r;
  axis_res_t res_x;
  axis_res_t res_y;

  ppc_axis u_axis_col (
    .clk    (clk),
    .q_mag  (qx),
    .neg    (div_out_tag.negx),
    .center (ccol_r),
    .dim    (width_r),
    .res    (res_x)
  );

  ppc_axis u_axis_row (
    .clk    (clk),
    .q_mag  (qy),
    .neg    (div_out_tag.negy),
    .center (crow_r),
    .dim    (height_r),
    .res    (res_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_tag_r.vld <= 1'b0;
    end else begin
      ax_tag_r.vld <= div_out_tag.vld;
    end
    ax_tag_r.ok   <= div_out_tag.ok;
    ax_tag_r.negx <= div_out_tag.negx;
    ax_tag_r.negy <= div_out_tag.negy;
    ax_tag_r.id   <= div_out_tag.id;
  end

  // output register: drop culled points
  logic      out_strobe_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ax_tag_r.vld && ax_tag_r.ok && res_x.ok && res_y.ok;
    end
    out_item_r.hit_id    <= ax_tag_r.id;
    out_item_r.pixel_col <= res_x.pix;
    out_item_r.pixel_row <= res_y.pix;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

[verif/tb_pinhole_point_projection_cull.sv]
// Self-checking testbench for the pinhole projection and cull pipeline.
`timescale 1ns / 1ps

module tb_pinhole_point_projection_cull
  import ppc_pkg::*;
();

  localparam int LATENCY  = 33;
  localparam int WDOG_MAX = 20000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_ADDR_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

  pinhole_point_projection_cull u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the camera registers
  logic [63:0] focal_q, ccol_q, crow_q, near_q, far_q, width_q, height_q;

  out_item_t hit_queue[$];
  int mismatches;
  int hits_seen;
  int points_sent;
  int wdog;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit fov_ok(input longint c, input logic [63:0] z,
                                input logic [63:0] dim);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = 2 * (abs64(c) * focal_q);
    rhs = (z * dim) << FRAC_BITS;
    return lhs < rhs;
  endfunction

  function automatic bit axis_pixel(input longint c, input logic [63:0] z,
                                    input logic [63:0] center,
                                    input logic [63:0] dim,
                                    output logic [PIX_WIDTH-1:0] pix);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] lim;
    longint q;
    longint u;
    longint lo;
    longint hi;
    n = abs64(c) * focal_q;
    lo = longint'(dim << FRAC_BITS);
    hi = longint'((99 * dim) << FRAC_BITS);
    if (c >= 0) q = longint'(n / z);
    else q = -longint'((n + z - 1) / z);
    u = q + longint'(center);
    pix = '0;
    if (100 * u < lo || 100 * u >= hi) return 1'b0;
    r = (64'(u) + 64'h8000) >> FRAC_BITS;
    lim = dim - 1;
    if (lim > 4095) lim = 4095;
    if (r > lim) r = lim;
    pix = r[PIX_WIDTH-1:0];
    return 1'b1;
  endfunction

  task automatic predict_hit(input in_item_t it);
    longint x;
    longint y;
    longint z;
    out_item_t h;
    logic [PIX_WIDTH-1:0] col;
    logic [PIX_WIDTH-1:0] row;
    x = longint'(it.cam_x);
    y = longint'(it.cam_y);
    z = longint'(it.cam_z);
    if (z < longint'(near_q) || z > longint'(far_q) || z <= 0) return;
    if (!fov_ok(x, 64'(z), width_q) || !fov_ok(y, 64'(z), height_q)) return;
    if (!axis_pixel(x, 64'(z), ccol_q, width_q, col)) return;
    if (!axis_pixel(y, 64'(z), crow_q, height_q, row)) return;
    h.hit_id = it.pt_index;
    h.pixel_col = col;
    h.pixel_row = row;
    hit_queue.insert(hit_queue.size(), h);
  endtask

  // checker and watchdog
  always @(posedge clk) begin
    int wdog_nxt;
    wdog_nxt = wdog + 1;
    if (rst_n) begin
      if (start && !busy) wdog_nxt = 0;
      if (out_strobe) begin
        wdog_nxt = 0;
        hits_seen <= hits_seen + 1;
        if (hit_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected hit: expected none, got %h", out_item);
        end else begin
          if (out_item !== hit_queue[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("hit mismatch: expected id %h col %0d row %0d, got id %h col %0d row %0d",
                       hit_queue[0].hit_id, hit_queue[0].pixel_col,
                       hit_queue[0].pixel_row, out_item.hit_id,
                       out_item.pixel_col, out_item.pixel_row);
          end
          void'(hit_queue.pop_front());
        end
      end
      wdog <= wdog_nxt;
      if (wdog >= WDOG_MAX) begin
        $display("watchdog expired");
        $display("pinhole_point_projection_cull test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FOCAL:  focal_q = 64'(val);
      REG_CCOL:   ccol_q = 64'(val[28:0]);
      REG_CROW:   crow_q = 64'(val[28:0]);
      REG_NEAR:   near_q = 64'(val[30:0]);
      REG_FAR:    far_q = 64'(val[30:0]);
      REG_WIDTH:  width_q = 64'(val[12:0]);
      REG_HEIGHT: height_q = 64'(val[12:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic setup_camera(input logic [31:0] f, input logic [31:0] cc,
                              input logic [31:0] cr, input logic [31:0] nd,
                              input logic [31:0] fd, input logic [31:0] w,
                              input logic [31:0] h);
    drain_pipe();
    write_reg(REG_FOCAL, f);
    write_reg(REG_CCOL, cc);
    write_reg(REG_CROW, cr);
    write_reg(REG_NEAR, nd);
    write_reg(REG_FAR, fd);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // one beat on the point channel; start stays high into the next beat
  task automatic send_point(input in_item_t it);
    if (idle_on) begin
      while ($urandom_range(99) < 17) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_hit(it);
    points_sent++;
  endtask

  task automatic send_xyz(input longint x, input longint y, input longint z);
    in_item_t it;
    it.pt_index = ID_WIDTH'($urandom);
    it.cam_x = COORD_WIDTH'(x);
    it.cam_y = COORD_WIDTH'(y);
    it.cam_z = COORD_WIDTH'(z);
    send_point(it);
  endtask

  // point aimed inside the view, with random content
  function automatic in_item_t aimed_point();
    in_item_t it;
    longint z;
    longint span;
    z = longint'(near_q) + longint'($urandom_range(32'hFFFF_FFFF) %
        ((far_q > near_q ? far_q - near_q : 0) + 1));
    span = longint'(64'(z) * width_q * 65536 / (2 * (focal_q == 0 ? 1 : focal_q)));
    it.pt_index = ID_WIDTH'($urandom);
    it.cam_x = COORD_WIDTH'($signed(64'($urandom)) % (span + 1) *
                            (($urandom & 1) ? 1 : -1));
    span = longint'(64'(z) * height_q * 65536 / (2 * (focal_q == 0 ? 1 : focal_q)));
    it.cam_y = COORD_WIDTH'($signed(64'($urandom)) % (span + 1) *
                            (($urandom & 1) ? 1 : -1));
    it.cam_z = COORD_WIDTH'(z);
    return it;
  endfunction

  task automatic test_directed();
    send_xyz(0, 0, 65536 * 10);
    send_xyz(0, 0, 65536);
    send_xyz(0, 0, 26214400);
    send_xyz(0, 0, 65535);
    send_xyz(0, 0, 26214401);
    send_xyz(0, 0, 0);
    send_xyz(0, 0, -65536);
    send_xyz(-2147483647 - 1, -2147483647 - 1, -2147483647 - 1);
    send_xyz(2147483647, 2147483647, 2147483647);
    send_xyz(65536 * 5, 65536 * 3, 65536 * 10);
    send_xyz(-65536 * 5, -65536 * 3, 65536 * 10);
    send_xyz(65536 * 9, 0, 65536 * 10);
    send_xyz(-65536 * 9, 0, 65536 * 10);
    send_xyz(0, 65536 * 5, 65536 * 10);
    send_xyz(0, -65536 * 5, 65536 * 10);
    send_xyz(-1, -1, 65536);
    begin
      in_item_t it;
      it = '{pt_index: 24'hFFFFFF, cam_x: 0, cam_y: 0, cam_z: 65536 * 2};
      send_point(it);
      it.pt_index = 0;
      send_point(it);
    end
  endtask

  task automatic test_random(input int count);
    in_item_t it;
    repeat (count) begin
      if ($urandom_range(99) < 75) it = aimed_point();
      else begin
        it.pt_index = ID_WIDTH'($urandom);
        it.cam_x = $urandom;
        it.cam_y = $urandom;
        it.cam_z = ($urandom & 1) ? $urandom : $urandom_range(65536 * 500);
      end
      send_point(it);
    end
  endtask

  task automatic test_camera_sweep();
    setup_camera(65536, 0, 0, 1, 32'h7FFF_FFFF, 1, 1);          // one-pixel image
    test_random(60);
    setup_camera(32'hFFFF_FFFF, 268435456, 268435456, 1, 32'h7FFF_FFFF, 4096, 4096);
    test_random(100);
    setup_camera(65536 * 2, 65536 * 2, 65536 * 2, 65536, 65536 * 100, 4, 4);
    test_random(100);
    setup_camera(0, 65536 * 8, 65536 * 8, 65536, 65536 * 100, 16, 16);
    test_random(40);
    setup_camera(65536 * 500, 65536 * 320, 65536 * 240, 65536 * 50, 65536 * 10, 640, 480);
    test_random(40);                                            // near above far
    setup_camera(65536 * 500, 65536 * 320, 65536 * 240, 65536, 65536 * 50, 0, 480);
    test_random(40);                                            // zero width
    setup_camera(65536 * 800, 65536 * 4000, 65536 * 4000, 65536, 65536 * 200, 8191, 8191);
    test_random(100);                                           // clamp saturates
    setup_camera($urandom, $urandom_range(268435456), $urandom_range(268435456),
                 $urandom_range(65536 * 4), $urandom_range(65536 * 1000, 65536 * 4),
                 $urandom_range(4096, 1), $urandom_range(4096, 1));
    test_random(100);
  endtask

  task automatic test_no_idle();
    setup_camera(65536000, 62914560, 35389440, 65536, 26214400, 1920, 1080);
    idle_on = 1'b0;
    test_random(200);
    idle_on = 1'b1;
    drain_pipe();                                               // sender waits for every hit
    test_random(150);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatches = 0;
    hits_seen = 0;
    points_sent = 0;
    wdog = 0;
    idle_on = 1'b1;
    focal_q = 65536000; ccol_q = 62914560; crow_q = 35389440;
    near_q = 65536; far_q = 26214400; width_q = 1920; height_q = 1080;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(100);
    test_camera_sweep();
    test_no_idle();
    drain_pipe();
    $display("sent %0d points through the reset camera and nine reprogrammed ones",
             points_sent);
    $display("checked %0d hits, including a stretch of back-to-back points", hits_seen);
    if (mismatches == 0 && hit_queue.size() == 0)
      $display("pinhole_point_projection_cull test passed");
    else
      $display("pinhole_point_projection_cull test failed");
    $finish;
  end

endmodule
